// ===== rtl/windowed_packet_loss_monitor_defines.svh =====
// assertion macros for the windowed packet loss monitor
`ifndef WINDOWED_PACKET_LOSS_MONITOR_DEFINES_SVH
`define WINDOWED_PACKET_LOSS_MONITOR_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define WPLM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define WPLM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WPLM_ASSERT(lbl, prop, msg)
`define WPLM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/wplm_pkg.sv =====
// shared constants, types and helpers of the windowed packet loss monitor
`timescale 1ns / 1ps
`default_nettype none
package wplm_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int GAP_BITS   = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam int SEQ_W  = 32;
	localparam int TIME_W = 32;
	localparam int WIN_W  = 20;
	localparam int LOSS_W = 10;
	localparam int LOST_W = 22;
	localparam int EVT_W  = 23;
	localparam int PROD_W = 32;

	localparam int LOSS_SCALE = 1000;
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5000);
	localparam logic [GAP_BITS-1:0] LOST_CAP = '1;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int REG_W  = ADDR_W - 2;
	localparam logic [REG_W-1:0] REG_WINDOW = '0;

	typedef struct packed {
		logic [TIME_W-1:0]   stamp;
		logic [GAP_BITS-1:0] lost;
	} entry_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t wdata;
	} fifo_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		entry_t           head;
	} fifo_stat_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [EVT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [LOSS_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FULL,
		ST_PUSH,
		ST_WAIT,
		ST_PRUNE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(FIFO_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/wplm_if.sv =====
// valid/ready channel interfaces for packet beats and result beats
`timescale 1ns / 1ps
`default_nettype none
interface wplm_in_if;
	logic                     valid;
	logic                     ready;
	logic [wplm_pkg::SEQ_W-1:0]  sequence_req;
	logic [wplm_pkg::TIME_W-1:0] now_ms;

	modport source (output valid, output sequence_req, output now_ms, input ready);
	modport sink (input valid, input sequence_req, input now_ms, output ready);
endinterface

interface wplm_out_if;
	logic                        valid;
	logic                        ready;
	logic [wplm_pkg::LOSS_W-1:0] loss_tenths_percent;
	logic [wplm_pkg::LOST_W-1:0] lost_in_window;
	logic [wplm_pkg::EVT_W-1:0]  events_in_window;
	logic                        sequence_new;

	modport source (output valid, output loss_tenths_percent, output lost_in_window,
		output events_in_window, output sequence_new, input ready);
	modport sink (input valid, input loss_tenths_percent, input lost_in_window,
		input events_in_window, input sequence_new, output ready);
endinterface
`default_nettype wire

// ===== rtl/wplm_cfg.sv =====
// apb register block holding the window length
`timescale 1ns / 1ps
`default_nettype none
module wplm_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wplm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [wplm_pkg::DATA_W-1:0] pwdata,
	output logic      [wplm_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output logic      [wplm_pkg::WIN_W-1:0]  window
);
	logic [wplm_pkg::WIN_W-1:0] window_q;
	logic [wplm_pkg::REG_W-1:0] reg_idx;
	logic                       wr_en;

	assign reg_idx = paddr[wplm_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign window  = window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= wplm_pkg::WINDOW_RESET;
		end else if (wr_en && reg_idx == wplm_pkg::REG_WINDOW) begin
			window_q <= pwdata[wplm_pkg::WIN_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			wplm_pkg::REG_WINDOW: prdata = wplm_pkg::DATA_W'(window_q);
			default:              prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/wplm_entry_fifo.sv =====
// run-length entry store: ring memory with head, tail and fill count
`timescale 1ns / 1ps
`default_nettype none
module wplm_entry_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire wplm_pkg::fifo_cmd_t  cmd,
	output wplm_pkg::fifo_stat_t      stat
);
	wplm_pkg::entry_t mem [wplm_pkg::FIFO_DEPTH];
	wplm_pkg::entry_t rd_q;

	logic [wplm_pkg::PTR_W-1:0] head_q;
	logic [wplm_pkg::PTR_W-1:0] tail_q;
	logic [wplm_pkg::CNT_W-1:0] count_q;

	// head entry read every cycle and registered, so it follows the head pointer in the next cycle
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= cmd.wdata;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q <= wplm_pkg::next_ptr(tail_q);
			end
			if (cmd.pop) begin
				head_q <= wplm_pkg::next_ptr(head_q);
			end
			count_q <= count_q + wplm_pkg::CNT_W'(cmd.push) - wplm_pkg::CNT_W'(cmd.pop);
		end
	end

	assign stat.count = count_q;
	assign stat.head  = rd_q;
endmodule
`default_nettype wire

// ===== rtl/wplm_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module wplm_divider (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wplm_pkg::div_req_t  req,
	output wplm_pkg::div_rsp_t       rsp
);
	localparam int DSH_W = wplm_pkg::EVT_W + wplm_pkg::LOSS_W - 1;
	localparam int CMP_W = ((wplm_pkg::PROD_W > DSH_W) ? wplm_pkg::PROD_W : DSH_W) + 1;
	localparam int STEP_W = $clog2(wplm_pkg::LOSS_W + 1);

	logic [wplm_pkg::PROD_W-1:0] rem_q;
	logic [DSH_W-1:0]            dsh_q;
	logic [wplm_pkg::LOSS_W-1:0] quo_q;
	logic [STEP_W-1:0]           step_q;
	logic                        busy_q;
	logic                        done_q;

	logic [CMP_W-1:0] rem_x;
	logic [CMP_W-1:0] dsh_x;
	logic             ge;

	assign rem_x = CMP_W'(rem_q);
	assign dsh_x = CMP_W'(dsh_q);
	assign ge    = rem_x >= dsh_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(wplm_pkg::LOSS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient is known to fit, so the divisor starts aligned to its top bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= DSH_W'(req.divisor) << (wplm_pkg::LOSS_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= wplm_pkg::PROD_W'(rem_x - dsh_x);
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[wplm_pkg::LOSS_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/windowed_packet_loss_monitor.sv =====
// top level of the windowed packet loss monitor
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_packet_loss_monitor_defines.svh"
// Each packet beat on pkt carries a sequence number and the current millisecond
// time. A first packet, or one whose sequence is larger than the last one seen,
// stores a run-length entry (gap as lost events, saturated to 16 bits, plus one
// received event) stamped with the time; any other packet stores nothing. Then
// entries whose modular age exceeds window_ms are dropped oldest first, and one
// result beat on res reports lost and total events in the window and the loss in
// tenths of a percent. A full store of 64 entries drops its oldest before a push.
// A packet passes the store, the age walk, the scale step and the divide: the
// walk reads one entry per visit through the single registered read port of
// the entry memory, and the ratio comes from a divider that makes one quotient
// bit per cycle. pkt is ready only between packets; a finished result waits in
// its own output register, so the next packet can be taken while res is
// stalled. window_ms is the APB register at byte address 0.
module windowed_packet_loss_monitor (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wplm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [wplm_pkg::DATA_W-1:0] pwdata,
	output logic      [wplm_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	wplm_in_if.sink                          pkt,
	wplm_out_if.source                       res
);
	wplm_pkg::state_t state_q, state_d;

	logic [wplm_pkg::WIN_W-1:0] window;

	wplm_pkg::fifo_cmd_t  fifo_cmd;
	wplm_pkg::fifo_stat_t fifo_stat;
	wplm_pkg::div_req_t   div_req;
	wplm_pkg::div_rsp_t   div_rsp;

	// sequence tracking
	logic [wplm_pkg::SEQ_W-1:0] last_seq_q;
	logic                       awaiting_q;

	// captured packet
	logic [wplm_pkg::TIME_W-1:0]   now_q;
	logic [wplm_pkg::GAP_BITS-1:0] gap_q;
	logic                          new_q;

	// running window totals
	logic [wplm_pkg::LOST_W-1:0] lost_tot_q;
	logic [wplm_pkg::EVT_W-1:0]  evt_tot_q;

	logic [wplm_pkg::PROD_W-1:0] prod_q;

	// ratio of the packet in flight, moved out with the rest of the result
	logic [wplm_pkg::LOSS_W-1:0] loss_q;

	// result register
	logic                        out_valid_q;
	logic [wplm_pkg::LOSS_W-1:0] out_loss_q;
	logic [wplm_pkg::LOST_W-1:0] out_lost_q;
	logic [wplm_pkg::EVT_W-1:0]  out_evt_q;
	logic                        out_new_q;

	logic                          pkt_acc;
	logic                          is_new;
	logic [wplm_pkg::SEQ_W-1:0]    diff;
	logic [wplm_pkg::GAP_BITS-1:0] gap;
	logic [wplm_pkg::TIME_W-1:0]   age;
	logic                          keep;
	logic                          out_load;
	logic                          loss_zero;
	logic                          loss_take;

	wplm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.window  (window)
	);

	wplm_entry_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fifo_cmd),
		.stat   (fifo_stat)
	);

	wplm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pkt.ready = (state_q == wplm_pkg::ST_IDLE);
	assign pkt_acc   = pkt.valid && pkt.ready;

	// new sequence and its saturated gap
	assign is_new = awaiting_q || (pkt.sequence_req > last_seq_q);
	assign diff   = pkt.sequence_req - last_seq_q - wplm_pkg::SEQ_W'(1);
	always_comb begin
		if (awaiting_q) begin
			gap = '0;
		end else if (|diff[wplm_pkg::SEQ_W-1:wplm_pkg::GAP_BITS]) begin
			gap = wplm_pkg::LOST_CAP;
		end else begin
			gap = diff[wplm_pkg::GAP_BITS-1:0];
		end
	end

	// modular age of the oldest entry; a future stamp looks very old
	assign age  = now_q - fifo_stat.head.stamp;
	assign keep = age <= wplm_pkg::TIME_W'(window);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wplm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: store, age walk, scale, divide, hand off
	always_comb begin
		state_d          = state_q;
		fifo_cmd.push    = 1'b0;
		fifo_cmd.pop     = 1'b0;
		fifo_cmd.wdata   = '{stamp: now_q, lost: gap_q};
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = evt_tot_q;
		out_load         = 1'b0;
		loss_zero        = 1'b0;
		loss_take        = 1'b0;
		unique case (state_q)
			wplm_pkg::ST_IDLE: begin
				if (pkt_acc) begin
					state_d = wplm_pkg::ST_FULL;
				end
			end
			wplm_pkg::ST_FULL: begin
				if (new_q) begin
					// full store gives up its oldest entry first
					if (fifo_stat.count == wplm_pkg::CNT_W'(wplm_pkg::FIFO_DEPTH)) begin
						fifo_cmd.pop = 1'b1;
					end
					state_d = wplm_pkg::ST_PUSH;
				end else begin
					state_d = wplm_pkg::ST_WAIT;
				end
			end
			wplm_pkg::ST_PUSH: begin
				fifo_cmd.push = 1'b1;
				state_d       = wplm_pkg::ST_WAIT;
			end
			wplm_pkg::ST_WAIT: begin
				// head entry read settles
				state_d = wplm_pkg::ST_PRUNE;
			end
			wplm_pkg::ST_PRUNE: begin
				if (fifo_stat.count != '0 && !keep) begin
					fifo_cmd.pop = 1'b1;
					state_d      = wplm_pkg::ST_WAIT;
				end else begin
					state_d = wplm_pkg::ST_MUL;
				end
			end
			wplm_pkg::ST_MUL: begin
				if (evt_tot_q == '0) begin
					loss_zero = 1'b1;
					state_d   = wplm_pkg::ST_DONE;
				end else begin
					state_d = wplm_pkg::ST_DIV;
					div_req.start = 1'b0;
				end
			end
			wplm_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					loss_take = 1'b1;
					state_d   = wplm_pkg::ST_DONE;
				end
			end
			wplm_pkg::ST_DONE: begin
				if (!out_valid_q || res.ready) begin
					out_load = 1'b1;
					state_d  = wplm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wplm_pkg::ST_IDLE;
			end
		endcase
		// divider kicks off as the product lands
		if (state_q == wplm_pkg::ST_MUL && evt_tot_q != '0) begin
			div_req.start = 1'b1;
		end
	end

	// product is registered in the prune state, so it is ready when the scale step starts the divider
	always_ff @(posedge clk) begin
		if (state_q == wplm_pkg::ST_PRUNE) begin
			prod_q <= wplm_pkg::PROD_W'(lost_tot_q) * wplm_pkg::PROD_W'(wplm_pkg::LOSS_SCALE);
		end
		if (pkt_acc) begin
			now_q <= pkt.now_ms;
			gap_q <= gap;
			new_q <= is_new;
		end
		if (loss_zero) begin
			prod_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q <= '0;
			awaiting_q <= 1'b1;
			lost_tot_q <= '0;
			evt_tot_q  <= '0;
		end else begin
			if (pkt_acc && is_new) begin
				last_seq_q <= pkt.sequence_req;
				awaiting_q <= 1'b0;
			end
			if (fifo_cmd.pop) begin
				lost_tot_q <= lost_tot_q - wplm_pkg::LOST_W'(fifo_stat.head.lost);
				evt_tot_q  <= evt_tot_q - wplm_pkg::EVT_W'(fifo_stat.head.lost)
					- wplm_pkg::EVT_W'(1);
			end else if (fifo_cmd.push) begin
				lost_tot_q <= lost_tot_q + wplm_pkg::LOST_W'(gap_q);
				evt_tot_q  <= evt_tot_q + wplm_pkg::EVT_W'(gap_q) + wplm_pkg::EVT_W'(1);
			end
		end
	end

	// result payload; the ratio waits in loss_q while an older beat is still held
	always_ff @(posedge clk) begin
		if (loss_zero) begin
			loss_q <= '0;
		end else if (loss_take) begin
			loss_q <= div_rsp.quotient;
		end
		if (out_load) begin
			out_loss_q <= loss_q;
			out_lost_q <= lost_tot_q;
			out_evt_q  <= evt_tot_q;
			out_new_q  <= new_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid               = out_valid_q;
	assign res.loss_tenths_percent = out_loss_q;
	assign res.lost_in_window      = out_lost_q;
	assign res.events_in_window    = out_evt_q;
	assign res.sequence_new        = out_new_q;

	`WPLM_ASSERT(a_totals_match_count, evt_tot_q == wplm_pkg::EVT_W'(lost_tot_q) + wplm_pkg::EVT_W'(fifo_stat.count), "event total differs from lost total plus entry count")
	`WPLM_ASSERT(a_loss_bounded, out_valid_q |-> out_loss_q <= wplm_pkg::LOSS_W'(wplm_pkg::LOSS_SCALE), "loss ratio above full scale")
	`WPLM_ASSERT_ALWAYS(a_count_in_range, fifo_stat.count <= wplm_pkg::CNT_W'(wplm_pkg::FIFO_DEPTH), "entry count above store depth")
endmodule
`default_nettype wire

// ===== verif/loss_report_checker.sv =====
// scoreboard for the windowed packet loss monitor: predicts each report and compares it
`timescale 1ns / 1ps
module loss_report_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [wplm_pkg::ADDR_W-1:0] paddr,
	input  logic [wplm_pkg::DATA_W-1:0] pwdata,
	wplm_in_if                          pkt,
	wplm_out_if                         res,
	output int                          error_count,
	output int                          outstanding,
	output int                          reports_checked,
	output int                          store_evictions,
	output int                          stale_packets
);
	import wplm_pkg::*;

	typedef struct packed {
		logic [LOSS_W-1:0] loss_tenths_percent;
		logic [LOST_W-1:0] lost_in_window;
		logic [EVT_W-1:0]  events_in_window;
		logic              sequence_new;
	} report_t;

	logic [WIN_W-1:0]  window_len;
	logic [SEQ_W-1:0]  last_seq;
	logic              awaiting_first;
	logic [LOST_W-1:0] lost_sum;
	logic [EVT_W-1:0]  event_sum;
	entry_t            window_entries[$];
	report_t           pending_reports[$];

	// oldest entry leaves the window and its counts leave the sums
	task automatic retire_oldest_entry();
		entry_t e;
		e = window_entries[0];
		window_entries.delete(0);
		lost_sum  = lost_sum - LOST_W'(e.lost);
		event_sum = event_sum - EVT_W'(e.lost) - EVT_W'(1);
	endtask

	task automatic predict_loss_report(input logic [SEQ_W-1:0] seq,
		input logic [TIME_W-1:0] now, output report_t r);
		logic [SEQ_W-1:0]  gap;
		logic [TIME_W-1:0] age;
		logic [PROD_W-1:0] scaled;
		entry_t            e;
		logic              record;
		r = '0;
		record = 1'b0;
		e.stamp = now;
		e.lost = '0;
		if (awaiting_first) begin
			awaiting_first = 1'b0;
			record = 1'b1;
		end else if (seq > last_seq) begin
			gap = seq - last_seq - SEQ_W'(1);
			e.lost = (gap > SEQ_W'(LOST_CAP)) ? LOST_CAP : gap[GAP_BITS-1:0];
			record = 1'b1;
		end else begin
			stale_packets++;
		end
		if (record) begin
			// full store makes room by dropping its oldest run
			if (window_entries.size() >= FIFO_DEPTH) begin
				retire_oldest_entry();
				store_evictions++;
			end
			window_entries.insert(window_entries.size(), e);
			lost_sum  = lost_sum + LOST_W'(e.lost);
			event_sum = event_sum + EVT_W'(e.lost) + EVT_W'(1);
			last_seq = seq;
			r.sequence_new = 1'b1;
		end
		// age walk from the oldest, modular so wrapped and future stamps behave
		while (window_entries.size() > 0) begin
			age = now - window_entries[0].stamp;
			if (age <= TIME_W'(window_len)) break;
			retire_oldest_entry();
		end
		if (event_sum != '0) begin
			scaled = PROD_W'(lost_sum) * PROD_W'(LOSS_SCALE);
			r.loss_tenths_percent = LOSS_W'(scaled / PROD_W'(event_sum));
		end
		r.lost_in_window = lost_sum;
		r.events_in_window = event_sum;
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		report_t got;
		if (!arst_n) begin
			window_len = WINDOW_RESET;
			last_seq = '0;
			awaiting_first = 1'b1;
			lost_sum = '0;
			event_sum = '0;
			window_entries.delete();
			pending_reports.delete();
			error_count = 0;
			outstanding = 0;
			reports_checked = 0;
			store_evictions = 0;
			stale_packets = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_WINDOW) begin
				window_len = pwdata[WIN_W-1:0];
			end
			if (res.valid && res.ready) begin
				got.loss_tenths_percent = res.loss_tenths_percent;
				got.lost_in_window = res.lost_in_window;
				got.events_in_window = res.events_in_window;
				got.sequence_new = res.sequence_new;
				if (pending_reports.size() == 0) begin
					error_count++;
					if (error_count <= 10) begin
						$display("%t unexpected report loss=%0d lost=%0d events=%0d new=%0d",
							$realtime, got.loss_tenths_percent, got.lost_in_window,
							got.events_in_window, got.sequence_new);
					end
				end else begin
					want = pending_reports[0];
					pending_reports.delete(0);
					reports_checked++;
					if (got.loss_tenths_percent != want.loss_tenths_percent ||
						got.lost_in_window != want.lost_in_window ||
						got.events_in_window != want.events_in_window ||
						got.sequence_new != want.sequence_new) begin
						error_count++;
						if (error_count <= 10) begin
							$display("%t report mismatch: expected loss=%0d lost=%0d events=%0d new=%0d",
								$realtime, want.loss_tenths_percent, want.lost_in_window,
								want.events_in_window, want.sequence_new);
							$display("%t                   actual loss=%0d lost=%0d events=%0d new=%0d",
								$realtime, got.loss_tenths_percent, got.lost_in_window,
								got.events_in_window, got.sequence_new);
						end
					end
				end
			end
			if (pkt.valid && pkt.ready) begin
				predict_loss_report(pkt.sequence_req, pkt.now_ms, want);
				pending_reports.insert(pending_reports.size(), want);
			end
			outstanding = pending_reports.size();
		end
	end

endmodule

// ===== verif/tb_windowed_packet_loss_monitor.sv =====
// testbench top for the windowed packet loss monitor: stimulus, apb setup and verdict
`timescale 1ns / 1ps
module tb_windowed_packet_loss_monitor;
	import wplm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 500;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASE_ITEMS = 67;
	localparam logic [ADDR_W-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
	// byte address of a register index that does not exist
	localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(4);

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int error_count;
	int outstanding;
	int reports_checked;
	int store_evictions;
	int stale_packets;

	// stimulus-side bookkeeping
	logic              src_idle_en;
	logic              snk_idle_en;
	logic              hold_off_req;
	int                hold_offs;
	int                window_writes;
	int                beats_sent;
	logic              seen_first;
	logic [SEQ_W-1:0]  seq_hi;
	logic [TIME_W-1:0] clock_ms;

	wplm_in_if  pkt_bus();
	wplm_out_if res_bus();

	windowed_packet_loss_monitor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pkt     (pkt_bus),
		.res     (res_bus)
	);

	loss_report_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pkt             (pkt_bus),
		.res             (res_bus),
		.error_count     (error_count),
		.outstanding     (outstanding),
		.reports_checked (reports_checked),
		.store_evictions (store_evictions),
		.stale_packets   (stale_packets)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		int cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
		$display("tb_windowed_packet_loss_monitor: errors");
		$finish;
	end

	// result side: random ready, plus one long hold-off counted here so the
	// block fills its output register and stops taking packets
	initial begin
		int held;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_bus.ready = 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
				hold_off_req = 1'b0;
				hold_offs++;
			end
			if (snk_idle_en) begin
				res_bus.ready = ($urandom_range(99, 0) >= 36);
			end else begin
				res_bus.ready = 1'b1;
			end
		end
	end

	// apb write: setup cycle, then access cycle until pready; called at a falling edge
	task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (addr == ADDR_WINDOW) window_writes++;
	endtask

	// one packet beat; valid stays high into the next beat unless an idle gap comes
	task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] now);
		if (src_idle_en) begin
			while ($urandom_range(99, 0) < 36) begin
				pkt_bus.valid = 1'b0;
				@(negedge clk);
			end
		end
		pkt_bus.valid = 1'b1;
		pkt_bus.sequence_req = seq;
		pkt_bus.now_ms = now;
		do @(posedge clk); while (!pkt_bus.ready);
		@(negedge clk);
		beats_sent++;
		if (!seen_first || seq > seq_hi) begin
			seq_hi = seq;
			seen_first = 1'b1;
		end
	endtask

	// stop offering and let every report come back before touching the register
	task automatic settle();
		pkt_bus.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly orderly streams with random gaps; the rest is stale, jumping and
	// time-warped packets so the age walk and saturation are both exercised
	task automatic random_phase(input logic [WIN_W-1:0] win, input int items);
		int               n;
		int               pick;
		logic [31:0]      step_max;
		logic [SEQ_W-1:0] seq;
		logic [TIME_W-1:0] now;
		for (n = 0; n < items; n++) begin
			if (win == '0) begin
				step_max = 1;
			end else begin
				step_max = 32'(win) / (($urandom_range(1, 0) == 1) ? 32'd200 : 32'd8) + 1;
			end
			clock_ms = clock_ms + $urandom_range(step_max, 0);
			now = clock_ms;
			seq = seq_hi + 1;
			if ($urandom_range(3, 0) == 0) seq = seq + $urandom_range(20, 1);
			pick = $urandom_range(99, 0);
			if (pick < 72) begin
				// orderly stream
			end else if (pick < 80) begin
				seq = $urandom_range(seq_hi, 0);
			end else if (pick < 85) begin
				if (seq_hi < 32'hF000_0000) seq = seq_hi + $urandom_range(300000, 65536);
			end else if (pick < 89) begin
				if (seq_hi < 32'hC000_0000) seq = $urandom_range(32'hC000_0000, seq_hi);
			end else if (pick < 94) begin
				// stamp earlier than the entries already held
				now = clock_ms - $urandom_range(100000, 1);
			end else begin
				clock_ms = $urandom;
				now = clock_ms;
			end
			if (n == 40 && hold_offs == 0) hold_off_req = 1'b1;
			send_packet(seq, now);
		end
	endtask

	initial begin
		logic [WIN_W-1:0] phase_win[6];
		int               p;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pkt_bus.valid = 1'b0;
		pkt_bus.sequence_req = '0;
		pkt_bus.now_ms = '0;
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		hold_off_req = 1'b0;
		hold_offs = 0;
		window_writes = 0;
		beats_sent = 0;
		seen_first = 1'b0;
		seq_hi = '0;
		clock_ms = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset window of 5000 ms: first packet, repeat, stale, gap, saturated gap
		send_packet(32'd10, 32'd100);
		send_packet(32'd11, 32'd200);
		send_packet(32'd11, 32'd250);
		send_packet(32'd5, 32'd300);
		send_packet(32'd20, 32'd400);
		send_packet(32'd70020, 32'd500);
		// everything ages out, window empty
		send_packet(32'd70020, 32'd6000);
		send_packet(32'd70021, 32'd5400);
		// time steps back, held entry looks far in the future
		send_packet(32'd70022, 32'd100);
		// time wraps past zero and the modular age keeps the entry
		send_packet(32'd70023, 32'hFFFF_FF00);
		send_packet(32'd70024, 32'h0000_0100);
		send_packet(32'd0, 32'h0000_0200);
		settle();

		// zero window keeps only entries stamped exactly now
		write_register(ADDR_WINDOW, 32'd0);
		send_packet(32'd70030, 32'd700);
		send_packet(32'd70031, 32'd700);
		send_packet(32'd70032, 32'd701);
		settle();

		write_register(ADDR_WINDOW, 32'd1);
		send_packet(32'd70033, 32'd702);
		send_packet(32'd70034, 32'd704);
		settle();

		// a write to a register that does not exist, then all-ones masked to 20 bits
		write_register(ADDR_UNUSED, 32'h0000_0007);
		write_register(ADDR_WINDOW, 32'hFFFF_FFFF);
		send_packet(32'd70035, 32'd704 + 32'h000F_FFFF);
		clock_ms = 32'd704 + 32'h000F_FFFF;
		settle();

		phase_win[0] = WIN_W'(600000);
		phase_win[1] = WIN_W'(1);
		phase_win[2] = WIN_W'($urandom_range(600000, 1));
		phase_win[3] = '0;
		phase_win[4] = WINDOW_RESET;
		phase_win[5] = WIN_W'(600000);
		for (p = 0; p < 6; p++) begin
			// upper data bits are noise that the register drops
			write_register(ADDR_WINDOW, {12'($urandom), phase_win[p]});
			if (p == 3) write_register(ADDR_UNUSED, $urandom);
			// last phase runs with no idling on either side
			src_idle_en = (p != 5);
			snk_idle_en = (p != 5);
			random_phase(phase_win[p], PHASE_ITEMS);
			settle();
		end
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;

		// top sequence number, then nothing can be larger
		send_packet(32'hFFFF_FFFF, clock_ms);
		send_packet($urandom, clock_ms + 1);
		send_packet($urandom, clock_ms + 2);
		pkt_bus.valid = 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d packet beats and %0d reports over %0d window writes",
			beats_sent, reports_checked, window_writes);
		$display("  %0d stale packets, %0d full-store evictions, %0d receiver hold-offs",
			stale_packets, store_evictions, hold_offs);
		if (error_count == 0 && outstanding == 0) begin
			$display("tb_windowed_packet_loss_monitor: clean");
		end else begin
			$display("tb_windowed_packet_loss_monitor: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wplm_pkg.sv
rtl/wplm_if.sv
rtl/wplm_cfg.sv
rtl/wplm_entry_fifo.sv
rtl/wplm_divider.sv
rtl/windowed_packet_loss_monitor.sv
verif/loss_report_checker.sv
verif/tb_windowed_packet_loss_monitor.sv
